### sv/fifo_queue_lock_manager_macros.svh
// Assertion helpers for the queue lock manager.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef FIFO_QUEUE_LOCK_MANAGER_MACROS_SVH
`define FIFO_QUEUE_LOCK_MANAGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FQLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FQLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fqlm_pkg.sv
package fqlm_pkg;

    localparam int ID_W     = 5;
    localparam int STATUS_W = 3;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef logic [ID_W-1:0] id_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED = 3'd0,
        STAT_QUEUED  = 3'd1,
        STAT_HANDED  = 3'd2,
        STAT_FREED   = 3'd3,
        STAT_BAD     = 3'd4
    } fqlm_status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fqlm_state_t;

endpackage

### sv/fqlm_if.sv
interface fqlm_req_if
    import fqlm_pkg::*;
();
    logic valid;
    logic ready;
    logic command;
    id_t  requester;

    modport source (output valid, output command, output requester, input ready);
    modport sink   (input valid, input command, input requester, output ready);
endinterface

interface fqlm_rsp_if
    import fqlm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    id_t                 grant_id;
    logic                lock_free;

    modport source (output valid, output status, output grant_valid, output grant_id,
                    output lock_free, input ready);
    modport sink   (input valid, input status, input grant_valid, input grant_id,
                    input lock_free, output ready);
endinterface

### sv/fqlm_ram.sv
module fqlm_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/fifo_queue_lock_manager.sv
// Queue lock manager: one lock shared by REQUESTERS requesters, served in
// arrival order.
// Channels: req carries an item of command (0 acquire, 1 release) and
// requester id; rsp returns one item per request with status, grant_valid,
// grant_id and lock_free. Both use valid/ready; an item moves when both are
// high at a rising clk edge.
// A request accepted in the idle state moves to the execute state, which
// loads the response register; the receiver takes the response from that
// register. The successor-link RAM read issued at accept returns in the
// execute state, where the update runs, so no new request is taken until the
// block is back in idle. A new request is taken once the response register is
// empty or draining, so a stalled receiver holds the response in place and
// blocks the next request after it.
// Reset (rst_n low, asynchronous): lock free, no successor links, no pending
// response. The link RAM needs no clearing since each entry's data is used only
// while its valid flop is set; requests are taken right after reset.
module fifo_queue_lock_manager
    import fqlm_pkg::*;
#(
    parameter int REQUESTERS = 32
) (
    input logic       clk,
    input logic       rst_n,
    fqlm_req_if.sink  req,
    fqlm_rsp_if.source rsp
);

    localparam int AW = $clog2(REQUESTERS);

    fqlm_state_t state_reg, state_next;

    logic                  cmd_reg;
    id_t                   req_id_reg;
    logic                  tail_valid_reg, tail_valid_next;
    id_t                   tail_id_reg, tail_id_next;
    id_t                   holder_reg, holder_next;
    logic [REQUESTERS-1:0] succ_valid_reg, succ_valid_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  grant_valid_reg, grant_valid_next;
    id_t                   grant_id_reg, grant_id_next;
    logic                  lock_free_reg, lock_free_next;
    logic                  rsp_load;

    logic                  accept;
    logic                  in_range;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         t_addr;

    logic                  ram_we;
    id_t                   ram_rdata;

    assign req.ready = (state_reg == FSM_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign r_addr   = AW'(req_id_reg);
    assign t_addr   = AW'(tail_id_reg);
    assign in_range = 32'(req_id_reg) < REQUESTERS;

    fqlm_ram #(
        .WIDTH (ID_W),
        .DEPTH (REQUESTERS)
    ) u_succ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (t_addr),
        .wdata (req_id_reg),
        .re    (accept),
        .raddr (AW'(req.requester)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            tail_valid_reg <= 1'b0;
            tail_id_reg    <= '0;
            holder_reg     <= '0;
            succ_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tail_valid_reg <= tail_valid_next;
            tail_id_reg    <= tail_id_next;
            holder_reg     <= holder_next;
            succ_valid_reg <= succ_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.command;
            req_id_reg <= req.requester;
        end
        if (rsp_load)
        begin
            status_reg      <= status_next;
            grant_valid_reg <= grant_valid_next;
            grant_id_reg    <= grant_id_next;
            lock_free_reg   <= lock_free_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        tail_valid_next  = tail_valid_reg;
        tail_id_next     = tail_id_reg;
        holder_next      = holder_reg;
        succ_valid_next  = succ_valid_reg;
        rsp_load         = 1'b0;
        ram_we           = 1'b0;
        status_next      = STAT_BAD;
        grant_valid_next = 1'b0;
        grant_id_next    = '0;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next     = FSM_IDLE;
                rsp_load       = 1'b1;
                rsp_valid_next = 1'b1;
                if (!in_range)
                begin
                    status_next = STAT_BAD;
                end
                else if (cmd_reg == CMD_ACQUIRE)
                begin
                    // clear own link first, so a tail re-acquiring links to itself
                    succ_valid_next[r_addr] = 1'b0;
                    if (!tail_valid_reg)
                    begin
                        tail_valid_next  = 1'b1;
                        tail_id_next     = req_id_reg;
                        holder_next      = req_id_reg;
                        status_next      = STAT_GRANTED;
                        grant_valid_next = 1'b1;
                        grant_id_next    = req_id_reg;
                    end
                    else
                    begin
                        succ_valid_next[t_addr] = 1'b1;
                        ram_we                  = 1'b1;
                        tail_id_next            = req_id_reg;
                        status_next             = STAT_QUEUED;
                    end
                end
                else if (!tail_valid_reg || holder_reg != req_id_reg)
                begin
                    status_next = STAT_BAD;
                end
                else if (succ_valid_reg[r_addr])
                begin
                    // pass the lock down the link read at accept
                    succ_valid_next[r_addr] = 1'b0;
                    holder_next             = ram_rdata;
                    status_next             = STAT_HANDED;
                    grant_valid_next        = 1'b1;
                    grant_id_next           = ram_rdata;
                end
                else
                begin
                    tail_valid_next = 1'b0;
                    status_next     = STAT_FREED;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        lock_free_next = !tail_valid_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.grant_valid = grant_valid_reg;
    assign rsp.grant_id    = grant_id_reg;
    assign rsp.lock_free   = lock_free_reg;

`include "fifo_queue_lock_manager_macros.svh"

    `FQLM_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == FSM_EXEC, "accepted item did not enter execute")
    `FQLM_ASSERT_NOW(a_exec_slot_free, state_reg == FSM_EXEC, !rsp_valid_reg, "response register busy during execute")
    `FQLM_ASSERT_NOW(a_grant_holds_lock, rsp_valid_reg && grant_valid_reg, !lock_free_reg, "grant reported with lock free")
    `FQLM_ASSERT_NEXT(a_handover_holder, rsp_load && status_next == STAT_HANDED, holder_reg == grant_id_reg, "holder differs from handed grant")

endmodule
